// ===== hw/rtl/ced_pkg.sv =====
// Package with the result status codes and the result item type of the escape decoder.
`default_nettype none

package ced_pkg;

  localparam logic [1:0] STATUS_DATA   = 2'd0;
  localparam logic [1:0] STATUS_CHUNK  = 2'd1;
  localparam logic [1:0] STATUS_STRING = 2'd2;
  localparam logic [1:0] STATUS_ERROR  = 2'd3;

  typedef struct packed {
    logic       last;
    logic [1:0] status;
    logic [7:0] char_out;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/color_escape_decoder.sv =====
// Streaming decoder for terminal color style backslash, caret, octal and hex escapes.
//
// The slave channel takes one source character per item together with the
// character that ends the current chunk. The master channel gives one result
// item per handshake: a decoded byte, a chunk end, a string end or an error.
// One input item gives zero, one or two result items, and tlast marks the
// final result of each input item.
// An input item is decoded in the cycle it is accepted, and its results are
// registered into the result queue. The decode is one mode register and an
// 8-bit shift-accumulate, so one item is taken every cycle while each item
// gives at most one result and the receiver takes each one. A three-entry
// result queue sets the input side: s_tready is high while the queue holds
// at most one result, so an item that closes a numeric run with two results
// stalls the next item. When the receiver stalls, results stay in the queue
// and s_tready falls once two of them wait. Reset holds s_tready low, empties
// the queue, returns to plain character mode and clears the accumulator.
`default_nettype none

module color_escape_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // char_in [7:0], terminator [15:8]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // char_out [7:0]
  output logic [1:0]       m_tuser,   // status [1:0]
  output logic             m_tlast
);

  localparam logic [2:0] MODE_PLAIN  = 3'd0;
  localparam logic [2:0] MODE_BSLASH = 3'd1;
  localparam logic [2:0] MODE_CARET  = 3'd2;
  localparam logic [2:0] MODE_OCT    = 3'd3;
  localparam logic [2:0] MODE_HEX    = 3'd4;

  logic [2:0] mode, mode_next;
  logic [7:0] acc, acc_next;

  ced_pkg::result_t q [3];
  ced_pkg::result_t q_next [3];
  logic [1:0] count, count_next;

  logic [7:0] c, term;
  logic       accept, pop;

  logic             p_emit;
  ced_pkg::result_t p_res;
  logic [2:0]       p_mode;

  logic [3:0] hex_val;
  logic       hex_ok;

  logic             emit0, emit1;
  ced_pkg::result_t r0, r1;

  logic [1:0] base;

  assign c      = s_tdata[7:0];
  assign term   = s_tdata[15:8];
  assign accept = s_tvalid && s_tready;
  assign pop    = m_tvalid && m_tready;

  assign s_tready = !rst && (count <= 2'd1);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = q[0].char_out;
  assign m_tuser  = q[0].status;
  assign m_tlast  = q[0].last;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= "0" && c <= "9") begin
      hex_val = c[3:0];
    end else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) begin
      hex_val = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    p_emit = 1'b1;
    p_mode = MODE_PLAIN;
    p_res  = '{last: 1'b0, status: ced_pkg::STATUS_DATA, char_out: c};
    if (c == 8'd0) begin
      p_res.status   = ced_pkg::STATUS_STRING;
      p_res.char_out = 8'd0;
    end else if (c == term) begin
      p_res.status   = ced_pkg::STATUS_CHUNK;
      p_res.char_out = 8'd0;
    end else if (c == "\\") begin
      p_emit = 1'b0;
      p_mode = MODE_BSLASH;
    end else if (c == "^") begin
      p_emit = 1'b0;
      p_mode = MODE_CARET;
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    emit0     = 1'b0;
    emit1     = 1'b0;
    r0        = '{last: 1'b0, status: ced_pkg::STATUS_DATA, char_out: c};
    r1        = p_res;
    unique case (mode)
      MODE_BSLASH: begin
        mode_next = MODE_PLAIN;
        emit0     = 1'b1;
        unique case (c)
          8'd0: begin
            r0.status   = ced_pkg::STATUS_ERROR;
            r0.char_out = 8'd0;
          end
          "a": r0.char_out = 8'h07;
          "b": r0.char_out = 8'h08;
          "e": r0.char_out = 8'h1B;
          "f": r0.char_out = 8'h0C;
          "n": r0.char_out = 8'h0A;
          "r": r0.char_out = 8'h0D;
          "t": r0.char_out = 8'h09;
          "v": r0.char_out = 8'h0B;
          "?": r0.char_out = 8'h7F;
          "_": r0.char_out = 8'h20;
          "x", "X": begin
            emit0     = 1'b0;
            acc_next  = 8'd0;
            mode_next = MODE_HEX;
          end
          default: begin
            if (c >= "0" && c <= "7") begin
              emit0     = 1'b0;
              acc_next  = {5'd0, c[2:0]};
              mode_next = MODE_OCT;
            end
          end
        endcase
      end
      MODE_CARET: begin
        mode_next = MODE_PLAIN;
        emit0     = 1'b1;
        if (c == 8'd0) begin
          r0.status   = ced_pkg::STATUS_ERROR;
          r0.char_out = 8'd0;
        end else if (c == "?") begin
          r0.char_out = 8'h7F;
        end else begin
          r0.char_out = c & 8'h1F;
        end
      end
      MODE_OCT: begin
        if (c >= "0" && c <= "7") begin
          acc_next = {acc[4:0], c[2:0]};
        end else begin
          emit0       = 1'b1;
          r0.char_out = acc;
          emit1       = p_emit;
          mode_next   = p_mode;
        end
      end
      MODE_HEX: begin
        if (hex_ok) begin
          acc_next = {acc[3:0], hex_val};
        end else begin
          emit0       = 1'b1;
          r0.char_out = acc;
          emit1       = p_emit;
          mode_next   = p_mode;
        end
      end
      default: begin
        emit0     = p_emit;
        r0        = p_res;
        mode_next = p_mode;
      end
    endcase
    r0.last = !emit1;
    r1.last = 1'b1;
  end

  always_comb begin
    q_next     = q;
    count_next = count;
    if (pop) begin
      q_next[0]  = q[1];
      q_next[1]  = q[2];
      count_next = count - 2'd1;
    end
    base = count_next;
    if (accept && emit0) begin
      q_next[base] = r0;
      count_next   = count_next + 2'd1;
      if (emit1) begin
        q_next[base + 2'd1] = r1;
        count_next          = count_next + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
    if (rst) begin
      count <= 2'd0;
      mode  <= MODE_PLAIN;
      acc   <= 8'd0;
    end else begin
      count <= count_next;
      if (accept) begin
        mode <= mode_next;
        acc  <= acc_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_color_escape_decoder.sv =====
// Self-checking testbench for the color escape decoder with a result-predicting scoreboard.
module tb_color_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] CARET     = 8'h5E;

  typedef enum logic [2:0] {
    DM_PLAIN,
    DM_BSLASH,
    DM_CARET,
    DM_OCT,
    DM_HEX
  } decode_mode_e;

  class escape_scoreboard;
    decode_mode_e     mode;
    logic [7:0]       acc;
    ced_pkg::result_t pending[$];
    int               errors;

    function new();
      mode   = DM_PLAIN;
      acc    = 8'h00;
      errors = 0;
    endfunction

    function void emit(logic [7:0] b, logic [1:0] st);
      ced_pkg::result_t r;
      r.char_out = (st == ced_pkg::STATUS_DATA) ? b : 8'h00;
      r.status   = st;
      r.last     = 1'b0;
      pending.push_back(r);
    endfunction

    function void plain(logic [7:0] c, logic [7:0] term);
      if (c == 8'h00) emit(8'h00, ced_pkg::STATUS_STRING);
      else if (c == term) emit(8'h00, ced_pkg::STATUS_CHUNK);
      else if (c == BACKSLASH) mode = DM_BSLASH;
      else if (c == CARET) mode = DM_CARET;
      else emit(c, ced_pkg::STATUS_DATA);
    endfunction

    function void note_char(logic [7:0] c, logic [7:0] term);
      int               n_start;
      int               digit;
      ced_pkg::result_t r;
      n_start = pending.size();
      digit   = -1;
      case (mode)
        DM_BSLASH: begin
          mode = DM_PLAIN;
          case (c)
            8'h00:    emit(8'h00, ced_pkg::STATUS_ERROR);
            "a":      emit(8'h07, ced_pkg::STATUS_DATA);
            "b":      emit(8'h08, ced_pkg::STATUS_DATA);
            "e":      emit(8'h1B, ced_pkg::STATUS_DATA);
            "f":      emit(8'h0C, ced_pkg::STATUS_DATA);
            "n":      emit(8'h0A, ced_pkg::STATUS_DATA);
            "r":      emit(8'h0D, ced_pkg::STATUS_DATA);
            "t":      emit(8'h09, ced_pkg::STATUS_DATA);
            "v":      emit(8'h0B, ced_pkg::STATUS_DATA);
            "?":      emit(8'h7F, ced_pkg::STATUS_DATA);
            "_":      emit(8'h20, ced_pkg::STATUS_DATA);
            "x", "X": begin
              acc  = 8'h00;
              mode = DM_HEX;
            end
            default: begin
              if (c >= "0" && c <= "7") begin
                acc  = {5'b00000, c[2:0]};
                mode = DM_OCT;
              end else begin
                emit(c, ced_pkg::STATUS_DATA);
              end
            end
          endcase
        end
        DM_CARET: begin
          mode = DM_PLAIN;
          if (c == 8'h00) emit(8'h00, ced_pkg::STATUS_ERROR);
          else if (c == "?") emit(8'h7F, ced_pkg::STATUS_DATA);
          else emit(c & 8'h1F, ced_pkg::STATUS_DATA);
        end
        DM_OCT: begin
          if (c >= "0" && c <= "7") begin
            acc = {acc[4:0], c[2:0]};
          end else begin
            mode = DM_PLAIN;
            emit(acc, ced_pkg::STATUS_DATA);
            plain(c, term);
          end
        end
        DM_HEX: begin
          if (c >= "0" && c <= "9") digit = c - "0";
          else if (c >= "A" && c <= "F") digit = c - "A" + 10;
          else if (c >= "a" && c <= "f") digit = c - "a" + 10;
          if (digit >= 0) begin
            acc = {acc[3:0], digit[3:0]};
          end else begin
            mode = DM_PLAIN;
            emit(acc, ced_pkg::STATUS_DATA);
            plain(c, term);
          end
        end
        default: begin
          mode = DM_PLAIN;
          plain(c, term);
        end
      endcase
      if (pending.size() > n_start) begin
        r = pending.pop_back();
        r.last = 1'b1;
        pending.push_back(r);
      end
    endfunction

    function void check_result(ced_pkg::result_t got);
      ced_pkg::result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result: actual char_out=%h status=%0d last=%0b",
                 $time, got.char_out, got.status, got.last);
        errors++;
      end else begin
        want = pending.pop_front();
        if (got.char_out !== want.char_out || got.status !== want.status ||
            got.last !== want.last) begin
          $display({"%0t: mismatch: expected char_out=%h status=%0d last=%0b, ",
                    "actual char_out=%h status=%0d last=%0b"},
                   $time, want.char_out, want.status, want.last,
                   got.char_out, got.status, got.last);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'h0000;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int tx_idle_pct = 29;
  int rx_idle_pct = 83;
  int chars_sent  = 0;

  escape_scoreboard sb = new();

  color_escape_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_char(s_tdata[7:0], s_tdata[15:8]);
      if (m_tvalid && m_tready) sb.check_result({m_tlast, m_tuser, m_tdata});
    end
  end

  task automatic send_char(input logic [7:0] c, input logic [7:0] term);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {term, c};
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_char(s[i], term);
  endtask

  // One chunk of mostly well-formed escapes, with some noise and broken escapes mixed in.
  task automatic send_chunk();
    logic [7:0] term;
    logic [7:0] c;
    string      letters;
    string      hexd;
    letters = "abefnrtv?_";
    hexd    = "0123456789abcdefABCDEF";
    case ($urandom_range(3))
      0:       term = "=";
      1:       term = ":";
      default: term = 8'($urandom_range(1, 255));
    endcase
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          do c = 8'($urandom_range(1, 255));
          while (c == term || c == BACKSLASH || c == CARET);
          send_char(c, term);
        end
        3: begin
          send_char(BACKSLASH, term);
          if ($urandom_range(1)) send_char(letters[$urandom_range(9)], term);
          else send_char(8'($urandom_range(1, 255)), term);
        end
        4: begin
          send_char(CARET, term);
          if ($urandom_range(3) == 0) send_char("?", term);
          else send_char(8'($urandom_range(1, 255)), term);
        end
        5: begin
          send_char(BACKSLASH, term);
          repeat ($urandom_range(1, 4)) send_char(8'(8'h30 + $urandom_range(7)), term);
        end
        6: begin
          send_char(BACKSLASH, term);
          send_char($urandom_range(1) ? "x" : "X", term);
          repeat ($urandom_range(3)) send_char(hexd[$urandom_range(21)], term);
        end
        7: begin
          send_char($urandom_range(1) ? BACKSLASH : CARET, term);
          send_char(term, term);
        end
        8: send_char(8'($urandom_range(255)), term);
        default: begin
          send_char($urandom_range(1) ? BACKSLASH : CARET, term);
          send_char(8'h00, term);
        end
      endcase
    end
    send_char(($urandom_range(7) == 0) ? 8'h00 : term, term);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_char(8'hFF, "=");
    send_char(8'hFF, 8'hFF);
    send_char(8'h00, 8'h00);
    send_text("\\e^?\\=", "=");
    send_text("\\101A", "=");
    send_text("\\x=", "=");
    send_text("\\Xf0", "0");
    send_char(8'h00, "0");
    send_char(BACKSLASH, "=");
    send_char(8'h00, "=");
    send_char(CARET, "=");
    send_char(8'h00, "=");

    while (chars_sent < 360) send_chunk();
    tx_idle_pct = 83;
    rx_idle_pct = 29;
    while (chars_sent < 700) send_chunk();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (chars_sent < 1040) send_chunk();
    s_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
